// File: hw/rtl/nat_pkg.sv
// Shared constants, codes and the walking token type of the node address table.
package nat_pkg;

   localparam int unsigned NODE_SLOTS = 32;
   localparam int unsigned ID_W       = 8;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 8;

   localparam logic [ID_W-1:0]   REJECT_ID = 8'd255;
   localparam logic [BYTE_W-1:0] MISS_MAX  = 8'd255;

   // request selector codes
   localparam logic [1:0] FUNC_ID_REQ    = 2'd0;
   localparam logic [1:0] FUNC_DATA_ACK  = 2'd1;
   localparam logic [1:0] FUNC_DATA_POLL = 2'd2;

   // id reply status codes
   localparam logic [1:0] ST_REUSED   = 2'd0;
   localparam logic [1:0] ST_NEW      = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REUSE_HOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_HOLD   = 8'd1;

   localparam logic [BYTE_W-1:0] REUSE_HOLD_RESET = 8'd3;
   localparam logic [BYTE_W-1:0] NEW_HOLD_RESET   = 8'd30;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOOKUP,
      OP_CLAIM,
      OP_ACK,
      OP_POLL
   } op_type;

   // word that walks down the row of slot cells, one cell per cycle
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [WORD_W-1:0] addr_high;
      logic [WORD_W-1:0] addr_mid;
      logic [WORD_W-1:0] addr_low;
      logic [ID_W-1:0]   target;
      logic [BYTE_W-1:0] device_kind;
      logic [BYTE_W-1:0] fault_kind;
      logic [BYTE_W-1:0] fault_level;
      logic              hit;
      logic [ID_W-1:0]   hit_id;
      logic              free_found;
      logic [ID_W-1:0]   free_id;
      logic              matched;
      logic [BYTE_W-1:0] miss;
   } token_type;

endpackage

// File: hw/rtl/nat_channels.sv
// Handshake channel interfaces: request, response and register write.
interface nat_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  func;
   logic [nat_pkg::WORD_W-1:0]  addr_high;
   logic [nat_pkg::WORD_W-1:0]  addr_mid;
   logic [nat_pkg::WORD_W-1:0]  addr_low;
   logic [nat_pkg::ID_W-1:0]    target_id;
   logic [nat_pkg::BYTE_W-1:0]  device_kind;
   logic [nat_pkg::BYTE_W-1:0]  fault_kind;
   logic [nat_pkg::BYTE_W-1:0]  fault_level;

   modport source (output valid, func, addr_high, addr_mid, addr_low, target_id,
                   device_kind, fault_kind, fault_level, input ready);
   modport sink (input valid, func, addr_high, addr_mid, addr_low, target_id,
                 device_kind, fault_kind, fault_level, output ready);
endinterface

interface nat_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [nat_pkg::ID_W-1:0]    assigned_id;
   logic [1:0]                  assign_status;
   logic [nat_pkg::BYTE_W-1:0]  hold_time;
   logic                        ack_matched;
   logic [nat_pkg::BYTE_W-1:0]  miss_count_now;
   logic                        id_out_of_range;

   modport source (output valid, assigned_id, assign_status, hold_time, ack_matched,
                   miss_count_now, id_out_of_range, input ready);
   modport sink (input valid, assigned_id, assign_status, hold_time, ack_matched,
                 miss_count_now, id_out_of_range, output ready);
endinterface

interface nat_csr_if;
   logic                           valid;
   logic                           ready;
   logic [nat_pkg::CSR_IDX_W-1:0]  index;
   logic [nat_pkg::BYTE_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/nat_cell.sv
// One table slot: holds the slot's fields and updates the passing token.
module nat_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [nat_pkg::ID_W-1:0]  cell_id,
   input  nat_pkg::token_type        up_tok,
   output nat_pkg::token_type        dn_tok
);

   nat_pkg::token_type          dn_tok_ff, dn_tok_in;
   logic                        occ_ff, occ_in;
   logic [nat_pkg::WORD_W-1:0]  addr_high_ff, addr_high_in;
   logic [nat_pkg::WORD_W-1:0]  addr_mid_ff, addr_mid_in;
   logic [nat_pkg::WORD_W-1:0]  addr_low_ff, addr_low_in;
   logic [nat_pkg::BYTE_W-1:0]  miss_ff, miss_in;
   logic [nat_pkg::BYTE_W-1:0]  device_kind_ff, device_kind_in;
   logic [nat_pkg::BYTE_W-1:0]  fault_kind_ff, fault_kind_in;
   logic [nat_pkg::BYTE_W-1:0]  fault_level_ff, fault_level_in;
   logic                        online_ff, online_in;
   logic                        addr_hit;
   logic                        id_hit;
   logic [nat_pkg::BYTE_W-1:0]  miss_bumped;

   assign addr_hit = occ_ff && (addr_high_ff == up_tok.addr_high)
                     && (addr_mid_ff == up_tok.addr_mid) && (addr_low_ff == up_tok.addr_low);
   assign id_hit = (up_tok.target == cell_id);
   assign miss_bumped = (miss_ff == nat_pkg::MISS_MAX) ? miss_ff : miss_ff + 8'd1;

   always_comb begin
      dn_tok_in      = up_tok;
      occ_in         = occ_ff;
      addr_high_in   = addr_high_ff;
      addr_mid_in    = addr_mid_ff;
      addr_low_in    = addr_low_ff;
      miss_in        = miss_ff;
      device_kind_in = device_kind_ff;
      fault_kind_in  = fault_kind_ff;
      fault_level_in = fault_level_ff;
      online_in      = online_ff;
      if (up_tok.valid) begin
         case (up_tok.op)
            nat_pkg::OP_LOOKUP: begin
               // only the first matching slot is reused
               if (addr_hit && !up_tok.hit) begin
                  dn_tok_in.hit    = 1'b1;
                  dn_tok_in.hit_id = cell_id;
                  miss_in          = '0;
               end
               if (!occ_ff && !up_tok.free_found) begin
                  dn_tok_in.free_found = 1'b1;
                  dn_tok_in.free_id    = cell_id;
               end
            end
            nat_pkg::OP_CLAIM: begin
               if (id_hit) begin
                  occ_in       = 1'b1;
                  addr_high_in = up_tok.addr_high;
                  addr_mid_in  = up_tok.addr_mid;
                  addr_low_in  = up_tok.addr_low;
               end
            end
            nat_pkg::OP_ACK: begin
               if (id_hit && occ_ff) begin
                  miss_in           = '0;
                  device_kind_in    = up_tok.device_kind;
                  fault_kind_in     = up_tok.fault_kind;
                  fault_level_in    = up_tok.fault_level;
                  online_in         = 1'b1;
                  dn_tok_in.matched = 1'b1;
               end
            end
            nat_pkg::OP_POLL: begin
               // a free slot still counts misses
               if (id_hit) begin
                  miss_in        = miss_bumped;
                  dn_tok_in.miss = miss_bumped;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_tok_ff      <= '0;
         occ_ff         <= 1'b0;
         addr_high_ff   <= '0;
         addr_mid_ff    <= '0;
         addr_low_ff    <= '0;
         miss_ff        <= '0;
         device_kind_ff <= '0;
         fault_kind_ff  <= '0;
         fault_level_ff <= '0;
         online_ff      <= 1'b0;
      end else begin
         dn_tok_ff      <= dn_tok_in;
         occ_ff         <= occ_in;
         addr_high_ff   <= addr_high_in;
         addr_mid_ff    <= addr_mid_in;
         addr_low_ff    <= addr_low_in;
         miss_ff        <= miss_in;
         device_kind_ff <= device_kind_in;
         fault_kind_ff  <= fault_kind_in;
         fault_level_ff <= fault_level_in;
         online_ff      <= online_in;
      end
   end

   assign dn_tok = dn_tok_ff;

endmodule

// File: hw/rtl/nat_chain.sv
// Row of slot cells; a token enters at the first slot (id 1) and leaves after the last slot.
module nat_chain (
   input  logic                clock,
   input  logic                reset,
   input  nat_pkg::token_type  head_tok,
   output nat_pkg::token_type  tail_tok
);

   nat_pkg::token_type tok [0:nat_pkg::NODE_SLOTS];

   assign tok[0] = head_tok;

   for (genvar k = 0; k < nat_pkg::NODE_SLOTS; k++) begin : g_cell
      nat_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (nat_pkg::ID_W'(k + 1)),
         .up_tok  (tok[k]),
         .dn_tok  (tok[k+1])
      );
   end

   assign tail_tok = tok[nat_pkg::NODE_SLOTS];

endmodule

// File: hw/rtl/node_address_assign_table.sv
// Node address table: id assignment by hardware address, poll and acknowledge tracking.
//
// Channels: req_bus takes one word per event (id request, data acknowledge or data
// poll); rsp_bus returns exactly one word per event; csr_bus writes the two hold
// time registers (index 0 reuse hold, index 1 new hold) and is always ready.
// Registers are meant to be written only while no event is in flight.
//
// Each event travels down a row of NODE_SLOTS slot cells, one cell per cycle. An id
// request that claims a free slot makes a second trip down the row to write the
// slot. One event is in the row at a time; the next is accepted as soon as the
// previous result has moved to the output register.
//
// Reset clears every slot, restores the hold registers to 3 and 30 and empties the
// output register. When the receiver stalls, the response holds in the output
// register; one more event may be accepted and walked, and its result waits until
// the output register frees up.
module node_address_assign_table (
   input  logic       clock,
   input  logic       reset,
   nat_req_if.sink    req_bus,
   nat_rsp_if.source  rsp_bus,
   nat_csr_if.sink    csr_bus
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_CLAIM,
      S_HOLD
   } state_type;

   state_type                   state_ff;
   nat_pkg::token_type          head_tok;
   nat_pkg::token_type          tail_tok;
   logic                        req_acc;
   logic                        claim_go;
   logic [nat_pkg::BYTE_W-1:0]  reuse_hold_ff;
   logic [nat_pkg::BYTE_W-1:0]  new_hold_ff;

   // finished result waiting for the output register
   logic [nat_pkg::ID_W-1:0]    res_id_ff, res_id_in;
   logic [1:0]                  res_status_ff, res_status_in;
   logic [nat_pkg::BYTE_W-1:0]  res_hold_ff, res_hold_in;
   logic                        res_matched_ff, res_matched_in;
   logic [nat_pkg::BYTE_W-1:0]  res_miss_ff, res_miss_in;
   logic                        res_oor_ff, res_oor_in;

   logic                        rsp_valid_ff;
   logic [nat_pkg::ID_W-1:0]    rsp_id_ff;
   logic [1:0]                  rsp_status_ff;
   logic [nat_pkg::BYTE_W-1:0]  rsp_hold_ff;
   logic                        rsp_matched_ff;
   logic [nat_pkg::BYTE_W-1:0]  rsp_miss_ff;
   logic                        rsp_oor_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_acc = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // no match anywhere: the claim goes back down to the first free slot
   assign claim_go = (state_ff == S_WALK) && tail_tok.valid
                     && (tail_tok.op == nat_pkg::OP_LOOKUP)
                     && !tail_tok.hit && tail_tok.free_found;

   always_comb begin
      head_tok = '0;
      if (req_acc) begin
         head_tok.valid       = 1'b1;
         head_tok.addr_high   = req_bus.addr_high;
         head_tok.addr_mid    = req_bus.addr_mid;
         head_tok.addr_low    = req_bus.addr_low;
         head_tok.target      = req_bus.target_id;
         head_tok.device_kind = req_bus.device_kind;
         head_tok.fault_kind  = req_bus.fault_kind;
         head_tok.fault_level = req_bus.fault_level;
         case (req_bus.func)
            nat_pkg::FUNC_ID_REQ:    head_tok.op = nat_pkg::OP_LOOKUP;
            nat_pkg::FUNC_DATA_ACK:  head_tok.op = nat_pkg::OP_ACK;
            nat_pkg::FUNC_DATA_POLL: head_tok.op = nat_pkg::OP_POLL;
            default:                 head_tok.op = nat_pkg::OP_NONE;
         endcase
      end else if (claim_go) begin
         head_tok        = tail_tok;
         head_tok.op     = nat_pkg::OP_CLAIM;
         head_tok.target = tail_tok.free_id;
      end
   end

   nat_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .head_tok (head_tok),
      .tail_tok (tail_tok)
   );

   always_comb begin
      res_id_in      = '0;
      res_status_in  = nat_pkg::ST_NONE;
      res_hold_in    = '0;
      res_matched_in = 1'b0;
      res_miss_in    = '0;
      res_oor_in     = 1'b0;
      case (tail_tok.op)
         nat_pkg::OP_LOOKUP: begin
            if (tail_tok.hit) begin
               res_id_in     = tail_tok.hit_id;
               res_status_in = nat_pkg::ST_REUSED;
               res_hold_in   = reuse_hold_ff;
            end else if (tail_tok.free_found) begin
               res_id_in     = tail_tok.free_id;
               res_status_in = nat_pkg::ST_NEW;
               res_hold_in   = new_hold_ff;
            end else begin
               res_id_in     = nat_pkg::REJECT_ID;
               res_status_in = nat_pkg::ST_REJECTED;
               res_hold_in   = reuse_hold_ff;
            end
         end
         nat_pkg::OP_ACK: begin
            res_matched_in = tail_tok.matched;
         end
         nat_pkg::OP_POLL: begin
            res_miss_in = tail_tok.miss;
            res_oor_in  = (tail_tok.target == '0)
                          || (tail_tok.target > nat_pkg::ID_W'(nat_pkg::NODE_SLOTS));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reuse_hold_ff <= nat_pkg::REUSE_HOLD_RESET;
         new_hold_ff   <= nat_pkg::NEW_HOLD_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == nat_pkg::CSR_REUSE_HOLD) begin
            reuse_hold_ff <= csr_bus.wdata;
         end else if (csr_bus.index == nat_pkg::CSR_NEW_HOLD) begin
            new_hold_ff <= csr_bus.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_HOLD, whenever the receiver is ready, the output register is refilled below
         if (rsp_bus.ready && state_ff != S_HOLD) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (tail_tok.valid) begin
                  res_id_ff      <= res_id_in;
                  res_status_ff  <= res_status_in;
                  res_hold_ff    <= res_hold_in;
                  res_matched_ff <= res_matched_in;
                  res_miss_ff    <= res_miss_in;
                  res_oor_ff     <= res_oor_in;
                  state_ff       <= claim_go ? S_CLAIM : S_HOLD;
               end
            end
            S_CLAIM: begin
               if (tail_tok.valid) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_id_ff      <= res_id_ff;
                  rsp_status_ff  <= res_status_ff;
                  rsp_hold_ff    <= res_hold_ff;
                  rsp_matched_ff <= res_matched_ff;
                  rsp_miss_ff    <= res_miss_ff;
                  rsp_oor_ff     <= res_oor_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.assigned_id     = rsp_id_ff;
   assign rsp_bus.assign_status   = rsp_status_ff;
   assign rsp_bus.hold_time       = rsp_hold_ff;
   assign rsp_bus.ack_matched     = rsp_matched_ff;
   assign rsp_bus.miss_count_now  = rsp_miss_ff;
   assign rsp_bus.id_out_of_range = rsp_oor_ff;

   // a token leaves the row only while the controller is waiting for it
   a_tail_when_walking: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> (state_ff == S_WALK || state_ff == S_CLAIM))
      else $error("token left the slot row while controller was not waiting");

   // a claim trip always ends in a new assignment
   a_claim_is_new: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLAIM && tail_tok.valid) |=> (res_status_ff == nat_pkg::ST_NEW))
      else $error("claim finished without new-assignment status");

   // a rejected request always carries the reject id
   a_reject_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.assign_status == nat_pkg::ST_REJECTED)
      |-> (rsp_bus.assigned_id == nat_pkg::REJECT_ID))
      else $error("reject response with wrong id");

endmodule
